// ----- hdl/rfidhex_pkg.sv -----
`default_nettype none

package rfidhex_pkg;

    localparam logic [7:0] FRAME_START      = 8'h02;
    localparam logic [7:0] FRAME_END        = 8'h03;
    localparam int         FRAME_CHARS      = 12;
    localparam int         FRAME_BYTES      = FRAME_CHARS / 2;
    localparam int         COUNT_W          = $clog2(FRAME_CHARS + 1);
    localparam logic [7:0] SYNC_LIMIT_RESET = 8'd14;
    localparam logic [7:0] ASCII_ZERO       = 8'd48;
    localparam logic [7:0] ALPHA_GAP        = 8'd7;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_DATA      = 3'd1,
        ST_SYNC_ERROR   = 3'd2,
        ST_TOO_SHORT    = 3'd3,
        ST_BAD_CHECKSUM = 3'd4,
        ST_OVERFLOW     = 3'd5
    } status_t;

    typedef logic [7:0] char_store_t [FRAME_CHARS];

    // One result as it leaves the decoder / enters the output register
    typedef struct packed {
        status_t     status;
        logic [2:0]  frame_length;
        logic [7:0]  tag_header;
        logic [31:0] tag_id;
        logic [7:0]  checksum_byte;
    } frame_result_t;

    // ASCII hex digit to value: subtract '0', then 7 more above 9, all mod 256
    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        begin
            v = c - ASCII_ZERO;
            if (v > 8'd9)
            begin
                v = v - ALPHA_GAP;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rfidhex_decode.sv -----
`default_nettype none

module rfidhex_decode
    import rfidhex_pkg::*;
(
    input  var char_store_t         char_store,
    input  wire logic [COUNT_W-1:0] char_count,
    output frame_result_t           result
);

    logic [7:0]   bytes [FRAME_BYTES];
    logic [7:0]   hi_val [FRAME_BYTES];
    logic [7:0]   lo_val [FRAME_BYTES];
    logic [7:0]   chk;
    logic [COUNT_W:0] len_wide;

    // Pairs decode in parallel; entries past the count are zero in the store,
    // which gives the zero-character pad for an odd count.
    always_comb
    begin
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            hi_val[k] = nibble_of(char_store[2*k]);
            lo_val[k] = nibble_of(char_store[2*k+1]);
            if (char_count > COUNT_W'(2 * k))
            begin
                bytes[k] = {hi_val[k][3:0], 4'h0} | lo_val[k];
            end
            else
            begin
                bytes[k] = 8'h00;
            end
        end
    end

    always_comb
    begin
        chk = 8'h00;
        for (int k = 0; k < FRAME_BYTES - 1; k++)
        begin
            chk = chk ^ bytes[k];
        end
    end

    assign len_wide = ({1'b0, char_count} + (COUNT_W+1)'(1)) >> 1;

    always_comb
    begin
        if (char_count < COUNT_W'(FRAME_CHARS))
        begin
            result.status = ST_TOO_SHORT;
        end
        else if (bytes[FRAME_BYTES-1] != chk)
        begin
            result.status = ST_BAD_CHECKSUM;
        end
        else
        begin
            result.status = ST_OK;
        end
        result.frame_length  = len_wide[2:0];
        result.tag_header    = bytes[0];
        result.tag_id        = {bytes[1], bytes[2], bytes[3], bytes[4]};
        result.checksum_byte = bytes[5];
    end

endmodule

`default_nettype wire

// ----- hdl/rfid_ascii_hex_frame_parser.sv -----
`default_nettype none

// Channel   Handshake            Payload
// --------  -------------------  -----------------------------------------------
// in        in_valid/in_ready    rx_byte[7:0], burst_end
// out       out_valid/out_ready  status[2:0], frame_length[2:0], tag_header[7:0],
//                                tag_id[31:0], checksum_byte[7:0]
// cfg       cfg_write_en         cfg_write_data[7:0] -> sync_error_limit
//
// One request per cycle while in_ready is high; a result appears on out the cycle after its input.
// Throughput is set by the single output register: input stalls only while a
// result sits there and out_ready is low.
// Reset: hunting for the start byte, store and counters cleared, limit 14.
// Requests that make no result (stored characters, start byte, tolerated
// strays) pass without touching the output register.

module rfid_ascii_hex_frame_parser
    import rfidhex_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write_en,
    input  wire logic [7:0]  cfg_write_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        burst_end,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [2:0]       frame_length,
    output logic [7:0]       tag_header,
    output logic [31:0]      tag_id,
    output logic [7:0]       checksum_byte
);

    // Frame state
    logic [7:0]         limit_reg;
    logic               in_frame_reg,  in_frame_next;
    logic [7:0]         stray_reg,     stray_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    char_store_t        store_reg,     store_next;

    // Output stage
    logic               out_valid_reg, out_valid_next;
    frame_result_t      out_reg,       out_next;

    frame_result_t      decoded;
    logic               accept;
    logic               emit;
    logic               store_wr;
    logic [7:0]         stray_inc;

    rfidhex_decode u_decode (
        .char_store (store_reg),
        .char_count (count_reg),
        .result     (decoded)
    );

    // Output register frees up when it is empty or being taken
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign stray_inc = stray_reg + 8'd1;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        stray_next    = stray_reg;
        count_next    = count_reg;
        emit          = 1'b0;
        store_wr      = 1'b0;
        out_next      = '0;

        if (accept)
        begin
            priority if (!in_frame_reg)
            begin
                // hunting: anything but start is a stray
                if (rx_byte == FRAME_START)
                begin
                    in_frame_next = 1'b1;
                end
                else
                begin
                    stray_next = stray_inc;
                    if (stray_inc > limit_reg)
                    begin
                        emit            = 1'b1;
                        out_next.status = ST_SYNC_ERROR;
                    end
                end
            end
            else if (rx_byte == FRAME_END)
            begin
                emit     = 1'b1;
                out_next = decoded;
            end
            else if (count_reg >= COUNT_W'(FRAME_CHARS))
            begin
                emit            = 1'b1;
                out_next.status = ST_OVERFLOW;
            end
            else
            begin
                // a start byte inside a frame lands here too, stored as data
                store_wr   = 1'b1;
                count_next = count_reg + COUNT_W'(1);
            end

            if (!emit && burst_end)
            begin
                emit            = 1'b1;
                out_next.status = ST_NO_DATA;
            end

            // any result restarts the hunt
            if (emit)
            begin
                in_frame_next = 1'b0;
                stray_next    = 8'd0;
                count_next    = '0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAME_CHARS; i++)
        begin
            if (emit)
            begin
                store_next[i] = 8'h00;
            end
            else if (store_wr && count_reg == COUNT_W'(i))
            begin
                store_next[i] = rx_byte;
            end
            else
            begin
                store_next[i] = store_reg[i];
            end
        end
    end

    always_comb
    begin
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= SYNC_LIMIT_RESET;
            in_frame_reg  <= 1'b0;
            stray_reg     <= 8'd0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FRAME_CHARS; i++)
            begin
                store_reg[i] <= 8'h00;
            end
        end
        else
        begin
            if (cfg_write_en)
            begin
                limit_reg <= cfg_write_data;
            end
            in_frame_reg  <= in_frame_next;
            stray_reg     <= stray_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            store_reg     <= store_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign frame_length  = out_reg.frame_length;
    assign tag_header    = out_reg.tag_header;
    assign tag_id        = out_reg.tag_id;
    assign checksum_byte = out_reg.checksum_byte;

endmodule

`default_nettype wire

// ----- hdl/rfidhex_checker.sv -----
`default_nettype none

module rfidhex_checker
    import rfidhex_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [2:0]  frame_length,
    input wire logic [7:0]  tag_header,
    input wire logic [31:0] tag_id,
    input wire logic [7:0]  checksum_byte
);

    // held status, length and tag id must not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(tag_id) && $stable(frame_length))
        else $error("result changed while stalled");

    // input backs off only while a result is stuck
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stage");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_NO_DATA
            || status == ST_SYNC_ERROR || status == ST_TOO_SHORT
            || status == ST_BAD_CHECKSUM || status == ST_OVERFLOW))
        else $error("status code out of range");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NO_DATA || status == ST_SYNC_ERROR
            || status == ST_OVERFLOW)
        |-> frame_length == 3'd0 && tag_header == 8'h00 && tag_id == 32'h0
            && checksum_byte == 8'h00)
        else $error("error result carries frame fields");

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK || status == ST_BAD_CHECKSUM)
        |-> frame_length == 3'(FRAME_BYTES))
        else $error("full frame with wrong length");

endmodule

bind rfid_ascii_hex_frame_parser rfidhex_checker u_rfidhex_checker (.*);

`default_nettype wire

// ----- tb/sv/rfid_ascii_hex_frame_parser_test.sv -----
`timescale 1ns / 1ps

import rfidhex_pkg::*;

// Tracks the parser state on the request side and holds the results it predicts.
class frame_scoreboard;
    logic [7:0]    sync_limit;
    logic          in_frame;
    logic [7:0]    stray_count;
    logic [3:0]    char_count;
    logic [7:0]    char_store [FRAME_CHARS];
    frame_result_t expected_q [$];
    int            errors;

    function new();
        sync_limit = SYNC_LIMIT_RESET;
        errors     = 0;
        restart_hunt();
    endfunction

    function void set_limit(input logic [7:0] value);
        sync_limit = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void restart_hunt();
        in_frame    = 1'b0;
        stray_count = 8'd0;
        char_count  = 4'd0;
        foreach (char_store[i])
        begin
            char_store[i] = 8'h00;
        end
    endfunction

    // '0' offset, then the letter gap above 9, both wrapping at 8 bits
    function logic [7:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        v = c - ASCII_ZERO;
        if (v > 8'd9)
        begin
            v = v - ALPHA_GAP;
        end
        return v;
    endfunction

    function void note_request(input logic [7:0] rx, input logic last);
        frame_result_t r;
        logic          got;
        logic [7:0]    decoded [FRAME_BYTES];
        logic [7:0]    hi;
        logic [7:0]    lo;
        logic [7:0]    b;
        logic [7:0]    chk;
        int            len;
        int            i;
        r   = '0;
        got = 1'b0;
        if (!in_frame)
        begin
            if (rx == FRAME_START)
            begin
                in_frame = 1'b1;
            end
            else
            begin
                stray_count = stray_count + 8'd1;
                if (stray_count > sync_limit)
                begin
                    r.status = ST_SYNC_ERROR;
                    got      = 1'b1;
                end
            end
        end
        else if (rx == FRAME_END)
        begin
            foreach (decoded[k])
            begin
                decoded[k] = 8'h00;
            end
            chk = 8'h00;
            len = 0;
            for (i = 0; i < char_count; i += 2)
            begin
                hi = char_value(char_store[i]);
                lo = char_value((i + 1 < char_count) ? char_store[i + 1] : 8'h00);
                b  = {hi[3:0], 4'h0} | lo;
                decoded[len] = b;
                if (len < 5)
                begin
                    chk = chk ^ b;
                end
                len++;
            end
            if (char_count < FRAME_CHARS)
            begin
                r.status = ST_TOO_SHORT;
            end
            else if (decoded[5] != chk)
            begin
                r.status = ST_BAD_CHECKSUM;
            end
            else
            begin
                r.status = ST_OK;
            end
            r.frame_length  = len[2:0];
            r.tag_header    = decoded[0];
            r.tag_id        = {decoded[1], decoded[2], decoded[3], decoded[4]};
            r.checksum_byte = decoded[5];
            got = 1'b1;
        end
        else if (char_count >= FRAME_CHARS)
        begin
            r.status = ST_OVERFLOW;
            got      = 1'b1;
        end
        else
        begin
            char_store[char_count] = rx;
            char_count             = char_count + 4'd1;
        end
        if (!got && last)
        begin
            r.status = ST_NO_DATA;
            got      = 1'b1;
        end
        if (got)
        begin
            expected_q.push_back(r);
            restart_hunt();
        end
    endfunction

    function void check_result(input frame_result_t seen);
        frame_result_t want;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result status=%0d len=%0d hdr=%02h id=%08h chk=%02h",
                     $time, seen.status, seen.frame_length, seen.tag_header, seen.tag_id,
                     seen.checksum_byte);
            errors++;
        end
        else
        begin
            want = expected_q.pop_front();
            if (seen !== want)
            begin
                $display("%0t: mismatch expected status=%0d len=%0d hdr=%02h id=%08h chk=%02h",
                         $time, want.status, want.frame_length, want.tag_header,
                         want.tag_id, want.checksum_byte);
                $display("%0t:          actual   status=%0d len=%0d hdr=%02h id=%08h chk=%02h",
                         $time, seen.status, seen.frame_length, seen.tag_header,
                         seen.tag_id, seen.checksum_byte);
                errors++;
            end
        end
    endfunction

    function void finish_check();
        if (expected_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
            errors += expected_q.size();
        end
    endfunction
endclass

module rfid_ascii_hex_frame_parser_test;

    // No-acceptance cycles before giving up; the receiver hold-off is the
    // longest legal stall, so this is many times that.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_PCT       = 29;

    // one serial byte request as it is queued for the driver
    typedef struct packed {
        logic [7:0] rx;
        logic       last;
    } serial_req_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_write_en;
    logic [7:0]    cfg_write_data;
    logic          in_valid;
    logic          in_ready;
    logic [7:0]    rx_byte;
    logic          burst_end;
    logic          out_valid;
    logic          out_ready;
    logic [2:0]    status;
    logic [2:0]    frame_length;
    logic [7:0]    tag_header;
    logic [31:0]   tag_id;
    logic [7:0]    checksum_byte;
    frame_result_t out_result;

    frame_scoreboard sb;
    serial_req_t     plan_q [$];
    logic [7:0]      limit_now;     // limit as last written, steers stray runs
    bit              no_idle;       // both sides run flat out while set
    bit              hold_req;      // asks the receiver for one long hold-off
    int              stall_cycles;

    rfid_ascii_hex_frame_parser u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .burst_end      (burst_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .frame_length   (frame_length),
        .tag_header     (tag_header),
        .tag_id         (tag_id),
        .checksum_byte  (checksum_byte)
    );

    assign out_result = {status, frame_length, tag_header, tag_id, checksum_byte};

    always #5 clk = ~clk;

    function automatic logic roll(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic void queue_req(input logic [7:0] rx, input logic last);
        plan_q.push_back('{rx, last});
    endfunction

    // ASCII hex digit; letters now and then in lower case, which the block
    // decodes by the same arithmetic into something else
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] base;
        if (n < 4'd10)
        begin
            base = 8'h30;
        end
        else if (roll(10))
        begin
            base = 8'h61 - 8'd10;
        end
        else
        begin
            base = 8'h41 - 8'd10;
        end
        return base + 8'(n);
    endfunction

    // any character except the end byte; a start byte here is stored as data
    function automatic logic [7:0] wild_char();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == FRAME_END)
        begin
            c = FRAME_START;
        end
        return c;
    endfunction

    // anything but a start byte while hunting
    function automatic logic [7:0] stray_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        if (c == FRAME_START)
        begin
            c = FRAME_END;
        end
        return c;
    endfunction

    // header, four id bytes and the XOR checksum; optionally corrupted
    function automatic logic [47:0] checked_bytes(input logic bad);
        logic [39:0] data;
        logic [7:0]  chk;
        data = {8'($urandom), 32'($urandom)};
        chk  = data[39:32] ^ data[31:24] ^ data[23:16] ^ data[15:8] ^ data[7:0];
        if (bad)
        begin
            chk = chk ^ 8'($urandom_range(1, 255));
        end
        return {data, chk};
    endfunction

    function automatic void plan_hex_frame(input logic [47:0] frame, input int last_pct,
                                           input int wild_pct);
        int i;
        queue_req(FRAME_START, roll(last_pct));
        for (i = 0; i < FRAME_CHARS; i++)
        begin
            queue_req(roll(wild_pct) ? wild_char() : hex_char(frame[47 - 4 * i -: 4]),
                      roll(last_pct));
        end
        queue_req(FRAME_END, roll(30));
    endfunction

    function automatic void plan_strays(input int n, input int last_pct);
        repeat (n)
        begin
            queue_req(stray_byte(), roll(last_pct));
        end
    endfunction

    // A random mix of well-formed frames with random content, frames with a bad
    // checksum, short frames, overruns, stray runs around the sync limit and plain noise.
    function automatic void plan_phase(input int count);
        int pick;
        int n;
        int target;
        target = plan_q.size() + count;
        while (plan_q.size() < target)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                plan_strays($urandom_range(0, 3), 0);
                plan_hex_frame(checked_bytes(1'b0), 1, 1);
            end
            else if (pick < 50)
            begin
                plan_hex_frame(checked_bytes(1'b1), 1, 1);
            end
            else if (pick < 65)
            begin
                n = $urandom_range(0, FRAME_CHARS - 1);
                queue_req(FRAME_START, roll(2));
                repeat (n)
                begin
                    queue_req(roll(50) ? hex_char(4'($urandom)) : wild_char(), roll(2));
                end
                queue_req(FRAME_END, roll(30));
            end
            else if (pick < 75)
            begin
                // one character past a full store
                queue_req(FRAME_START, 1'b0);
                repeat (FRAME_CHARS + 1)
                begin
                    queue_req(roll(70) ? hex_char(4'($urandom)) : wild_char(), 1'b0);
                end
            end
            else if (pick < 88)
            begin
                n = (int'(limit_now) < 18) ? int'(limit_now) + 2 : 20;
                plan_strays($urandom_range(1, n), 4);
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    queue_req(8'($urandom_range(255)), roll(20));
                end
            end
        end
    endfunction

    // Called just after a falling edge; returns at the falling edge after
    // the request went in, with valid still high so back-to-back requests
    // never drop it.
    task automatic send_request(input serial_req_t req);
        while (!no_idle && roll(IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        rx_byte   <= req.rx;
        burst_end <= req.last;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_request(req.rx, req.last);
        @(negedge clk);
    endtask

    // Wait until every predicted result is out and the output register is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0 || out_valid)
        begin
            @(negedge clk);
        end
        repeat (4)
        begin
            @(negedge clk);
        end
    endtask

    task automatic play_plan();
        while (plan_q.size() != 0)
        begin
            send_request(plan_q.pop_front());
        end
        settle();
    endtask

    // only ever called with the block idle
    task automatic write_limit(input logic [7:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        sb.set_limit(value);
        limit_now = value;
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request so
    // the output register fills and the input stalls.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= no_idle || !roll(IDLE_PCT);
            end
        end
    end

    // Result check and watchdog, both on the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(out_result);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles = 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("status: fail");
            $finish;
        end
        else
        begin
            stall_cycles++;
        end
    end

    initial
    begin
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 8'h00;
        in_valid       = 1'b0;
        rx_byte        = 8'h00;
        burst_end      = 1'b0;
        no_idle        = 1'b0;
        hold_req       = 1'b0;
        stall_cycles   = 0;
        limit_now      = SYNC_LIMIT_RESET;

        repeat (10)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed, at the reset limit: strays at both byte extremes, a burst
        // end on a stray, a clean frame, a start byte inside a frame, a short
        // frame of two characters, a burst end on a start byte, an end byte while
        // hunting.
        queue_req(8'h00, 1'b0);
        queue_req(8'hFF, 1'b1);
        plan_hex_frame(48'h00FF_A55A_7E7E, 0, 0);
        queue_req(FRAME_START, 1'b0);
        queue_req(FRAME_START, 1'b0);
        queue_req(8'hFF, 1'b0);
        queue_req(FRAME_END, 1'b0);
        queue_req(FRAME_START, 1'b1);
        queue_req(FRAME_END, 1'b0);
        play_plan();

        // every stray is a sync error
        write_limit(8'd0);
        plan_phase(200);
        play_plan();

        // never a sync error; one long stray run wraps the counter, and the
        // receiver holds off for a while at the start
        write_limit(8'd255);
        hold_req = 1'b1;
        plan_phase(200);
        queue_req(8'h00, 1'b1);
        plan_strays(300, 0);
        play_plan();

        // no idling on either side
        write_limit(8'($urandom_range(2, 254)));
        no_idle = 1'b1;
        plan_phase(200);
        play_plan();
        no_idle = 1'b0;

        write_limit(8'd1);
        plan_phase(200);
        play_plan();

        write_limit(SYNC_LIMIT_RESET);
        plan_phase(200);
        play_plan();

        // anything still coming out now was never predicted
        no_idle = 1'b1;
        repeat (20)
        begin
            @(negedge clk);
        end
        sb.finish_check();
        if (sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
